/* sv/plim_pkg.sv */
// Package for the piecewise linear interpolator: request and status codes,
// the request record that travels down the pipeline, and fixed widths.
// No dependencies.
`default_nettype none
package plim_pkg;

  localparam logic REQ_QUERY = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [2:0] ST_INTERP     = 3'd0;
  localparam logic [2:0] ST_CLAMP_LO   = 3'd1;
  localparam logic [2:0] ST_CLAMP_HI   = 3'd2;
  localparam logic [2:0] ST_ZERO_WIDTH = 3'd3;
  localparam logic [2:0] ST_TOO_SMALL  = 3'd4;

  localparam logic       REG_POINTS   = 1'b0;
  localparam logic [6:0] POINTS_RESET = 7'd2;
  localparam logic [6:0] MIN_POINTS   = 7'd2;
  localparam int         POINTS_MAX   = 64;

  // Quotient bits produced by the divider; larger quotients saturate.
  localparam int QBITS = 35;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  idx;
    logic [31:0] pos;
    logic [31:0] val;
    logic [31:0] x;
    logic [6:0]  n;
  } item_t;

endpackage
`default_nettype wire

/* sv/plim_search_stage.sv */
// One step of the pipelined binary search, with its own copy of the position
// table. Depends on plim_pkg.
`default_nettype none
module plim_search_stage import plim_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int CW    = 7,
  parameter bit FIRST = 1'b0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire item_t         item_i,
  input  wire logic [CW-1:0] lo_i,
  input  wire logic [CW-1:0] hi_i,
  input  wire logic [CW-1:0] mid_i,
  input  wire logic [31:0]   rd_i,
  output logic               v_o,
  output item_t              item_o,
  output logic [CW-1:0]      lo_o,
  output logic [CW-1:0]      hi_o,
  output logic [CW-1:0]      mid_o,
  output logic [31:0]        rd_o
);
  localparam int IW = $clog2(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic          v_r;
  item_t         item_r;
  logic [CW-1:0] lo_r, hi_r, mid_r, lo_nxt, hi_nxt, mid_nxt;
  logic [CW:0]   sum;
  logic [31:0]   rd_r;
  logic          we;

  always_comb begin
    lo_nxt = lo_i;
    hi_nxt = hi_i;
    if (!FIRST && (lo_i < hi_i)) begin
      if ($signed(rd_i) < $signed(item_i.x)) lo_nxt = CW'(mid_i + 1'b1);
      else hi_nxt = mid_i;
    end
    sum     = {1'b0, lo_nxt} + {1'b0, hi_nxt};
    mid_nxt = sum[CW:1];
    we      = v_i && (item_i.req_type == REQ_WRITE) && (int'(item_i.idx) < DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= v_i;
    item_r <= item_i;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    if (we) mem[IW'(item_i.idx)] <= item_i.pos;
    rd_r <= mem[IW'(mid_nxt)];
  end

  assign v_o    = v_r;
  assign item_o = item_r;
  assign lo_o   = lo_r;
  assign hi_o   = hi_r;
  assign mid_o  = mid_r;
  assign rd_o   = rd_r;
endmodule
`default_nettype wire

/* sv/plim_fetch.sv */
// Last search step and the segment fetch: reads both end points of the
// segment from the position and value tables. Depends on plim_pkg.
`default_nettype none
module plim_fetch import plim_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire item_t         item_i,
  input  wire logic [CW-1:0] lo_i,
  input  wire logic [CW-1:0] hi_i,
  input  wire logic [CW-1:0] mid_i,
  input  wire logic [31:0]   rd_i,
  output logic               v_o,
  output item_t              item_o,
  output logic [CW-1:0]      lo_o,
  output logic [31:0]        x0_o,
  output logic [31:0]        x1_o,
  output logic [31:0]        f0_o,
  output logic [31:0]        f1_o
);
  localparam int IW = $clog2(DEPTH);

  logic [31:0]   pos_mem [DEPTH];
  logic [31:0]   val_mem [DEPTH];
  logic          v_r;
  item_t         item_r;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [IW-1:0] addr_a, addr_b;
  logic [31:0]   x0_r, x1_r, f0_r, f1_r;
  logic          we;

  always_comb begin
    lo_nxt = lo_i;
    if ((lo_i < hi_i) && ($signed(rd_i) < $signed(item_i.x))) lo_nxt = CW'(mid_i + 1'b1);
    addr_a = IW'(CW'(lo_nxt - 1'b1));
    addr_b = IW'(lo_nxt);
    we     = v_i && (item_i.req_type == REQ_WRITE) && (int'(item_i.idx) < DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= v_i && (item_i.req_type == REQ_QUERY);
    item_r <= item_i;
    lo_r   <= lo_nxt;
    if (we) begin
      pos_mem[IW'(item_i.idx)] <= item_i.pos;
      val_mem[IW'(item_i.idx)] <= item_i.val;
    end
    x0_r <= pos_mem[addr_a];
    x1_r <= pos_mem[addr_b];
    f0_r <= val_mem[addr_a];
    f1_r <= val_mem[addr_b];
  end

  assign v_o    = v_r;
  assign item_o = item_r;
  assign lo_o   = lo_r;
  assign x0_o   = x0_r;
  assign x1_o   = x1_r;
  assign f0_o   = f0_r;
  assign f1_o   = f1_r;
endmodule
`default_nettype wire

/* sv/plim_lerp.sv */
// Segment classification, magnitude product and a one-bit-per-stage restoring
// divider, then the signed add and saturation. Depends on plim_pkg.
`default_nettype none
module plim_lerp import plim_pkg::*; #(
  parameter int CW = 7
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          v_i,
  input  wire item_t         item_i,
  input  wire logic [CW-1:0] lo_i,
  input  wire logic [31:0]   x0_i,
  input  wire logic [31:0]   x1_i,
  input  wire logic [31:0]   f0_i,
  input  wire logic [31:0]   f1_i,
  output logic               v_o,
  output logic [31:0]        value_o,
  output logic [2:0]         status_o
);
  typedef struct packed {
    logic        v;
    logic [2:0]  status;
    logic [31:0] val;
    logic        neg;
    logic [32:0] mdx;
    logic [32:0] mdf;
    logic [32:0] den;
  } cls_t;

  typedef struct packed {
    logic        v;
    logic [2:0]  status;
    logic [31:0] val;
    logic        neg;
    logic [32:0] den;
    logic [64:0] prod;
  } mul_t;

  typedef struct packed {
    logic             v;
    logic [2:0]       status;
    logic [31:0]      val;
    logic             neg;
    logic             ovf;
    logic [32:0]      den;
    logic [32:0]      rem;
    logic [QBITS-1:0] dvd;
    logic [QBITS-1:0] q;
  } div_t;

  cls_t cls_r, cls_nxt;
  mul_t mul_r;
  div_t div_r [QBITS+1];
  div_t div_nxt [QBITS+1];
  logic        v_r;
  logic [31:0] value_r, value_nxt;
  logic [2:0]  status_r;

  logic signed [32:0] dx, df, den;

  always_comb begin
    dx  = $signed({item_i.x[31], item_i.x}) - $signed({x0_i[31], x0_i});
    df  = $signed({f1_i[31], f1_i}) - $signed({f0_i[31], f0_i});
    den = $signed({x1_i[31], x1_i}) - $signed({x0_i[31], x0_i});
    cls_nxt.v      = v_i;
    cls_nxt.neg    = dx[32] ^ df[32] ^ den[32];
    cls_nxt.mdx    = dx[32] ? 33'(-dx) : 33'(dx);
    cls_nxt.mdf    = df[32] ? 33'(-df) : 33'(df);
    cls_nxt.den    = den[32] ? 33'(-den) : 33'(den);
    cls_nxt.val    = f0_i;
    cls_nxt.status = ST_INTERP;
    if (item_i.n < MIN_POINTS) begin
      cls_nxt.status = ST_TOO_SMALL;
      cls_nxt.val    = 32'd0;
    end else if (lo_i == '0) begin
      // Slot 0 was read on the upper port.
      cls_nxt.status = ST_CLAMP_LO;
      cls_nxt.val    = f1_i;
    end else if (int'(lo_i) >= int'(item_i.n)) begin
      cls_nxt.status = ST_CLAMP_HI;
    end else if (den == '0) begin
      cls_nxt.status = ST_ZERO_WIDTH;
    end
  end

  // The upper bits of the product are checked against the divisor once: if
  // they reach it, the quotient is at least 2^35 and saturates anyway.
  always_comb begin
    div_nxt[0].v      = mul_r.v;
    div_nxt[0].status = mul_r.status;
    div_nxt[0].val    = mul_r.val;
    div_nxt[0].neg    = mul_r.neg;
    div_nxt[0].den    = mul_r.den;
    div_nxt[0].ovf    = {3'b0, mul_r.prod[64:QBITS]} >= mul_r.den;
    div_nxt[0].rem    = {3'b0, mul_r.prod[64:QBITS]};
    div_nxt[0].dvd    = mul_r.prod[QBITS-1:0];
    div_nxt[0].q      = '0;
  end

  for (genvar i = 0; i < QBITS; i++) begin : g_div
    logic [33:0] t;
    logic        ge;
    always_comb begin
      t  = {div_r[i].rem, div_r[i].dvd[QBITS-1]};
      ge = t >= {1'b0, div_r[i].den};
      div_nxt[i+1]     = div_r[i];
      div_nxt[i+1].rem = ge ? 33'(t - {1'b0, div_r[i].den}) : t[32:0];
      div_nxt[i+1].dvd = {div_r[i].dvd[QBITS-2:0], 1'b0};
      div_nxt[i+1].q   = {div_r[i].q[QBITS-2:0], ge};
    end
  end

  logic signed [36:0] sum;
  logic               sat;
  always_comb begin
    sat = div_r[QBITS].ovf || (div_r[QBITS].q > {1'b1, {(QBITS-1){1'b0}}});
    if (div_r[QBITS].neg)
      sum = $signed({{5{div_r[QBITS].val[31]}}, div_r[QBITS].val}) -
            $signed({2'b0, div_r[QBITS].q});
    else
      sum = $signed({{5{div_r[QBITS].val[31]}}, div_r[QBITS].val}) +
            $signed({2'b0, div_r[QBITS].q});
    if (div_r[QBITS].status != ST_INTERP) value_nxt = div_r[QBITS].val;
    else if (sat) value_nxt = div_r[QBITS].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (sum > 37'sh0_7FFF_FFFF) value_nxt = 32'h7FFF_FFFF;
    else if (sum < -37'sh0_8000_0000) value_nxt = 32'h8000_0000;
    else value_nxt = sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cls_r.v <= 1'b0;
      mul_r.v <= 1'b0;
      v_r     <= 1'b0;
    end else begin
      cls_r.v <= cls_nxt.v;
      mul_r.v <= cls_r.v;
      v_r     <= div_r[QBITS].v;
    end
    cls_r.status <= cls_nxt.status;
    cls_r.val    <= cls_nxt.val;
    cls_r.neg    <= cls_nxt.neg;
    cls_r.mdx    <= cls_nxt.mdx;
    cls_r.mdf    <= cls_nxt.mdf;
    cls_r.den    <= cls_nxt.den;
    mul_r.status <= cls_r.status;
    mul_r.val    <= cls_r.val;
    mul_r.neg    <= cls_r.neg;
    mul_r.den    <= cls_r.den;
    mul_r.prod   <= 65'(cls_r.mdx * cls_r.mdf);
    value_r      <= value_nxt;
    status_r     <= div_r[QBITS].status;
  end

  for (genvar i = 0; i <= QBITS; i++) begin : g_divreg
    always_ff @(posedge clk) begin
      if (!rst_n) div_r[i].v <= 1'b0;
      else div_r[i].v <= div_nxt[i].v;
      div_r[i].status <= div_nxt[i].status;
      div_r[i].val    <= div_nxt[i].val;
      div_r[i].neg    <= div_nxt[i].neg;
      div_r[i].ovf    <= div_nxt[i].ovf;
      div_r[i].den    <= div_nxt[i].den;
      div_r[i].rem    <= div_nxt[i].rem;
      div_r[i].dvd    <= div_nxt[i].dvd;
      div_r[i].q      <= div_nxt[i].q;
    end
  end

  assign v_o      = v_r;
  assign value_o  = value_r;
  assign status_o = status_r;
endmodule
`default_nettype wire

/* sv/piecewise_linear_interpolator_unit.sv */
// Top level of the piecewise linear interpolator: configuration register,
// search pipeline, segment fetch and interpolation. Depends on plim_pkg.
//
// Requests enter on start (busy is always low, so one request per cycle is
// taken). A write request stores one breakpoint and yields no result; a
// query yields one result on out_valid, held for a single cycle.
// A request passes through ITER binary search steps, ITER = ceil(log2(N+1))
// for N = min(TABLE_DEPTH, 64), then the segment fetch and interpolation.
// Throughput is one request per cycle; each search step owns its own copy of
// the position table, and the quotient comes from a 35-stage restoring
// divider, one bit per stage.
// Writes travel down the same pipeline, so every query sees exactly the
// writes requested before it.
// points_in_use is read and written over the APB port at address 0 and must
// only change while no query is in flight.
// Reset clears the valid bits and sets points_in_use to 2; table contents
// are undefined until written. The receiver cannot stall, so no result is
// ever held back.
`default_nettype none
module piecewise_linear_interpolator_unit import plim_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_req_type,
  input  wire logic [5:0]  in_entry_index,
  input  wire logic [31:0] in_entry_position,
  input  wire logic [31:0] in_entry_value,
  input  wire logic [31:0] in_query_position,
  output logic             out_valid,
  output logic [31:0]      out_interpolated_value,
  output logic [2:0]       out_status,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int NMAX = (TABLE_DEPTH < POINTS_MAX) ? TABLE_DEPTH : POINTS_MAX;
  localparam int CW   = $clog2(NMAX + 1);
  localparam int ITER = $clog2(NMAX + 1);
  localparam int LAT  = ITER + 40;

  logic [6:0] points_r;
  logic [6:0] n;

  always_ff @(posedge clk) begin
    if (!rst_n) points_r <= POINTS_RESET;
    else if (psel && penable && pwrite && (paddr[2] == REG_POINTS))
      points_r <= pwdata[6:0];
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POINTS) ? {25'b0, points_r} : 32'd0;
  assign busy   = 1'b0;
  assign n      = (int'(points_r) > NMAX) ? 7'(NMAX) : points_r;

  logic          st_v    [ITER+1];
  item_t         st_item [ITER+1];
  logic [CW-1:0] st_lo   [ITER+1];
  logic [CW-1:0] st_hi   [ITER+1];
  logic [CW-1:0] st_mid  [ITER+1];
  logic [31:0]   st_rd   [ITER+1];

  assign st_v[0]             = start && !busy;
  assign st_item[0].req_type = in_req_type;
  assign st_item[0].idx      = in_entry_index;
  assign st_item[0].pos      = in_entry_position;
  assign st_item[0].val      = in_entry_value;
  assign st_item[0].x        = in_query_position;
  assign st_item[0].n        = n;
  assign st_lo[0]            = '0;
  assign st_hi[0]            = CW'(n);
  assign st_mid[0]           = '0;
  assign st_rd[0]            = 32'd0;

  for (genvar k = 0; k < ITER; k++) begin : g_search
    plim_search_stage #(.DEPTH(TABLE_DEPTH), .CW(CW), .FIRST(k == 0)) u_stage (
      .clk(clk), .rst_n(rst_n),
      .v_i(st_v[k]), .item_i(st_item[k]), .lo_i(st_lo[k]), .hi_i(st_hi[k]),
      .mid_i(st_mid[k]), .rd_i(st_rd[k]),
      .v_o(st_v[k+1]), .item_o(st_item[k+1]), .lo_o(st_lo[k+1]), .hi_o(st_hi[k+1]),
      .mid_o(st_mid[k+1]), .rd_o(st_rd[k+1])
    );
  end

  logic          f_v;
  item_t         f_item;
  logic [CW-1:0] f_lo;
  logic [31:0]   f_x0, f_x1, f_f0, f_f1;

  plim_fetch #(.DEPTH(TABLE_DEPTH), .CW(CW)) u_fetch (
    .clk(clk), .rst_n(rst_n),
    .v_i(st_v[ITER]), .item_i(st_item[ITER]), .lo_i(st_lo[ITER]), .hi_i(st_hi[ITER]),
    .mid_i(st_mid[ITER]), .rd_i(st_rd[ITER]),
    .v_o(f_v), .item_o(f_item), .lo_o(f_lo),
    .x0_o(f_x0), .x1_o(f_x1), .f0_o(f_f0), .f1_o(f_f1)
  );

  plim_lerp #(.CW(CW)) u_lerp (
    .clk(clk), .rst_n(rst_n),
    .v_i(f_v), .item_i(f_item), .lo_i(f_lo),
    .x0_i(f_x0), .x1_i(f_x1), .f0_i(f_f0), .f1_i(f_f1),
    .v_o(out_valid), .value_o(out_interpolated_value), .status_o(out_status)
  );

`ifndef SYNTHESIS
  a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_QUERY)) |-> ##LAT out_valid)
    else $error("query request produced no result");
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_req_type == REQ_WRITE)) |-> ##LAT !out_valid)
    else $error("write request produced a result");
  a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_TOO_SMALL)) |-> (out_interpolated_value == 32'd0))
    else $error("too-small table gave a nonzero value");
`endif
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for piecewise_linear_interpolator_unit: loads
// breakpoint tables, sends queries and compares every result with a local
// predictor. Depends on plim_pkg and the unit's RTL.
`timescale 1ns / 100ps
module tb_top;
  import plim_pkg::*;

  localparam int DEPTH = 64;
  localparam int DRAIN = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = REQ_QUERY;
  logic [5:0]  in_entry_index = '0;
  logic [31:0] in_entry_position = '0;
  logic [31:0] in_entry_value = '0;
  logic [31:0] in_query_position = '0;
  logic        out_valid;
  logic [31:0] out_interpolated_value;
  logic [2:0]  out_status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  piecewise_linear_interpolator_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_entry_index(in_entry_index),
    .in_entry_position(in_entry_position), .in_entry_value(in_entry_value),
    .in_query_position(in_query_position), .out_valid(out_valid),
    .out_interpolated_value(out_interpolated_value), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predictor state.
  logic signed [31:0] tbl_pos [DEPTH];
  logic signed [31:0] tbl_val [DEPTH];
  logic [6:0]         pts_cfg = POINTS_RESET;

  logic [34:0] pending_results [$];
  int          errors = 0;
  int          idle_pct = 0;

  // Expected value and status of one query, packed as {status, value}.
  function automatic logic [34:0] interp_predict(logic signed [31:0] xq);
    int unsigned n, lo, hi, mid;
    longint x0, x1, f0, f1, dx, df, den, r;
    logic [63:0] prod, q;
    bit neg;
    n = (pts_cfg > DEPTH) ? DEPTH : pts_cfg;
    if (n < MIN_POINTS) return {ST_TOO_SMALL, 32'd0};
    lo = 0;
    hi = n;
    while (lo < hi) begin
      mid = (lo + hi) >> 1;
      if (tbl_pos[mid] < xq) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return {ST_CLAMP_LO, tbl_val[0]};
    if (lo >= n) return {ST_CLAMP_HI, tbl_val[n-1]};
    x0 = tbl_pos[lo-1];
    x1 = tbl_pos[lo];
    f0 = tbl_val[lo-1];
    f1 = tbl_val[lo];
    den = x1 - x0;
    if (den == 0) return {ST_ZERO_WIDTH, tbl_val[lo-1]};
    dx = xq - x0;
    df = f1 - f0;
    prod = (dx < 0 ? -dx : dx) * (df < 0 ? -df : df);
    q = prod / (den < 0 ? -den : den);
    neg = ((dx < 0) != (df < 0)) != (den < 0);
    if (q > 64'h4_0000_0000) r = neg ? -64'sd2147483648 : 64'sd2147483647;
    else r = neg ? f0 - longint'(q) : f0 + longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return {ST_INTERP, r[31:0]};
  endfunction

  task automatic wait_gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Leaves start high so that back-to-back requests need no idle cycle.
  task automatic send_request(logic rtype, logic [5:0] idx, logic [31:0] p,
                              logic [31:0] v, logic [31:0] xq);
    wait_gap();
    start <= 1'b1;
    in_req_type <= rtype;
    in_entry_index <= idx;
    in_entry_position <= p;
    in_entry_value <= v;
    in_query_position <= xq;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (rtype == REQ_WRITE) begin
      tbl_pos[idx] = p;
      tbl_val[idx] = v;
    end else begin
      pending_results.push_back(interp_predict(xq));
    end
  endtask

  task automatic write_entry(int idx, logic [31:0] p, logic [31:0] v);
    send_request(REQ_WRITE, idx[5:0], p, v, $urandom());
  endtask

  task automatic query(logic [31:0] xq);
    send_request(REQ_QUERY, 6'($urandom()), $urandom(), $urandom(), xq);
  endtask

  // Waits until all results are in and the pipeline is empty of writes.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_points(logic [6:0] n);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'd0;
    pwdata <= {25'd0, n};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pts_cfg = n;
    @(posedge clk);
  endtask

  // Fills slots 0..n-1 with a sorted table spaced by 1 to step + 1 (repeats if dup).
  task automatic load_sorted(int n, int unsigned step, bit dup);
    logic signed [31:0] p;
    p = -$signed(32'(step) * 32'(n / 2));
    for (int i = 0; i < n; i++) begin
      write_entry(i, p, $urandom());
      if (!(dup && $urandom_range(3) == 0)) p = p + 1 + $urandom_range(step);
    end
  endtask

  // Query at random, well inside, at and around the breakpoints of the loaded table.
  function automatic logic [31:0] pick_query();
    int n, k;
    n = (pts_cfg > DEPTH) ? DEPTH : pts_cfg;
    k = $urandom_range(n - 1);
    case ($urandom_range(5))
      0: return $urandom();
      1: return tbl_pos[k];
      2: return tbl_pos[k] + 1;
      3: return tbl_pos[k] - 1;
      default: return tbl_pos[k] + $urandom_range(1 << 16);
    endcase
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    set_points(7'd1);
    write_entry(0, 32'sh0001_0000, 32'sh0005_0000);
    query(32'h0);
    set_points(7'd0);
    query(32'h7FFF_FFFF);
    set_points(7'd4);
    write_entry(1, 32'sh0002_0000, 32'sh0007_0000);
    write_entry(2, 32'sh0002_0000, 32'sh0009_0000);
    write_entry(3, 32'sh7FFF_FFFF, 32'sh8000_0000);
    query(32'sh0001_0000);
    query(32'sh8000_0000);
    query(32'sh0001_8000);
    query(32'sh0002_0000);
    query(32'sh0002_0001);
    query(32'sh7FFF_FFFF);
    query(32'sh7FFF_FFFE);
    set_points(7'd2);
    write_entry(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
    write_entry(1, 32'sh7FFF_FFFF, 32'sh8000_0000);
    query(32'sh0000_0000);
    query(32'sh8000_0001);
    write_entry(1, 32'sh8000_0000, 32'sh8000_0000);
    query(32'sh8000_0000);
    query(32'sh1234_5678);
  endtask

  // Unsorted entries exercise negative widths and saturation.
  task automatic test_unsorted();
    idle_pct = 20;
    set_points(7'd8);
    for (int i = 0; i < 8; i++) write_entry(i, $urandom(), $urandom());
    for (int i = 0; i < 40; i++) query($urandom_range(3) == 0 ? tbl_pos[i % 8] : $urandom());
  endtask

  task automatic test_random_tables();
    int sizes[6];
    int n;
    sizes = '{2, 64, 17, 3, 33, 64};
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 66 : 20;
      n = sizes[ph];
      // A count above the table depth is taken as the full table.
      set_points(ph == 5 ? 7'd127 : ph == 1 ? 7'd64 : 7'(n));
      load_sorted(n, ph % 2 ? 32'h0000_FFFF : 32'h0100_0000, ph > 2);
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(9) == 0) write_entry(64 + $urandom_range(63) - 64,
                                                tbl_pos[0], tbl_val[0]);
        query(pick_query());
      end
    end
  endtask

  // Checks each result in the cycle it is presented.
  always @(posedge clk) begin
    logic [34:0] exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time,
                 out_interpolated_value, out_status);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_interpolated_value !== exp_r[31:0]) begin
          $display("%0t: value expected %h actual %h", $time, exp_r[31:0],
                   out_interpolated_value);
          errors++;
        end
        if (out_status !== exp_r[34:32]) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r[34:32],
                   out_status);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_unsorted();
    test_random_tables();
    drain();
    if (errors == 0 && pending_results.size() == 0)
      $display("piecewise_linear_interpolator_unit verification clean");
    else
      $display("piecewise_linear_interpolator_unit verification failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("piecewise_linear_interpolator_unit verification failed");
    $finish;
  end
endmodule
